### rtl/flcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flcm_pkg: shared types and constants
// Widths, register indexes, state encodings and the beats that pass between
// the pixel lanes, the merge stage and the top level.
// ----------------------------------------------------------------------------
package flcm_pkg;

   localparam int CHAN_W       = 16;
   localparam int COEF_W       = 16;
   localparam int FLOOR_W      = 24;
   localparam int CSR_W        = 24;
   localparam int CSR_IDX_W    = 2;
   localparam int LUMA_SUM_W   = 40;
   localparam int CHROMA_SUM_W = 41;
   localparam int TALLY_W      = 25;
   localparam int MAX_PIXELS   = 16777216;
   localparam int CHROMA_W     = 17;
   localparam int PROD_W       = 2 * CHAN_W;
   localparam int SQSUM_W      = PROD_W + 2;
   localparam int BIT_IDX_W    = 5;
   localparam int MEAN_W       = 50;
   localparam int DIVD_W       = 58;
   localparam int DIVS_W       = 50;
   localparam int DIV_CNT_W    = 6;
   localparam int MANT_W       = 31;
   localparam int MSB_W        = 6;
   localparam int FRAC_W       = 16;
   localparam int LOG_W        = MSB_W + FRAC_W;
   localparam int OUT_W        = 16;
   localparam int EXPO_LIMIT   = 16384;
   localparam int RATIO_ONE    = 256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LUMA_RED,
      CSR_LUMA_GREEN,
      CSR_LUMA_BLUE,
      CSR_FLOOR
   } csr_index_type;

   typedef enum logic [2:0] {
      LN_IDLE,
      LN_LUMA,
      LN_SQUARE,
      LN_SUM,
      LN_ROOT,
      LN_DONE
   } lane_state_type;

   typedef enum logic [3:0] {
      MG_IDLE,
      MG_DIV_START,
      MG_DIV_WAIT,
      MG_CLAMP,
      MG_NORM,
      MG_SQUARE,
      MG_RATIO_CHECK,
      MG_RATIO_WAIT,
      MG_DONE
   } merge_state_type;

   typedef enum logic [1:0] {
      TP_IDLE,
      TP_LANE,
      TP_MERGE
   } top_state_type;

   typedef struct packed {
      logic                done;
      logic [CHAN_W-1:0]   luma;
      logic [CHROMA_W-1:0] chroma;
   } lane_out_type;

   typedef struct packed {
      logic             done;
      logic [OUT_W-1:0] exposure;
      logic [OUT_W-1:0] ratio;
   } merge_out_type;

endpackage
`default_nettype wire

### rtl/flcm_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flcm_lane: per-pixel luma and chroma
// Weighted luma, squared channel-minus-luma distances, and a bit-by-bit
// floor square root of their sum, one root bit per cycle.
// ----------------------------------------------------------------------------
module flcm_lane (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire [flcm_pkg::CHAN_W-1:0]   red,
   input  wire [flcm_pkg::CHAN_W-1:0]   green,
   input  wire [flcm_pkg::CHAN_W-1:0]   blue,
   input  wire [flcm_pkg::COEF_W-1:0]   coef_red,
   input  wire [flcm_pkg::COEF_W-1:0]   coef_green,
   input  wire [flcm_pkg::COEF_W-1:0]   coef_blue,
   output flcm_pkg::lane_out_type       res
);
   import flcm_pkg::*;

   lane_state_type          state_ff, state_in;
   logic [CHAN_W-1:0]       chan_ff [3];
   logic [PROD_W-1:0]       prod_ff [3];
   logic [PROD_W-1:0]       sq_ff   [3];
   logic [CHAN_W-1:0]       luma_ff;
   logic [SQSUM_W-1:0]      sumsq_ff;
   logic [CHROMA_W-1:0]     root_ff;
   logic [BIT_IDX_W-1:0]    bit_ff;

   logic [SQSUM_W-1:0]      prod_sum;
   logic [SQSUM_W-CHAN_W-1:0] luma_raw;
   logic [CHAN_W-1:0]       luma_sat;
   logic signed [CHAN_W:0]  diff [3];
   logic signed [2*CHAN_W+1:0] dsq [3];
   logic [SQSUM_W-1:0]      sq_total;
   logic [CHROMA_W-1:0]     cand;
   logic [2*CHROMA_W-1:0]   cand_sq;

   // luma: round the weighted sum, saturate to channel range
   always_comb begin
      prod_sum = SQSUM_W'(prod_ff[0]) + SQSUM_W'(prod_ff[1]) + SQSUM_W'(prod_ff[2])
               + SQSUM_W'(32768);
      luma_raw = prod_sum[SQSUM_W-1:CHAN_W];
      luma_sat = (luma_raw[SQSUM_W-CHAN_W-1:CHAN_W] != '0) ? '1 : luma_raw[CHAN_W-1:0];
   end

   // squared distances and their sum
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i] = $signed({1'b0, chan_ff[i]}) - $signed({1'b0, luma_ff});
         dsq[i]  = diff[i] * diff[i];
      end
      sq_total = SQSUM_W'(sq_ff[0]) + SQSUM_W'(sq_ff[1]) + SQSUM_W'(sq_ff[2]);
   end

   // root trial: keep the bit if its square still fits
   always_comb begin
      cand    = root_ff | (CHROMA_W'(1) << bit_ff);
      cand_sq = cand * cand;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         LN_IDLE:   if (start) state_in = LN_LUMA;
         LN_LUMA:   state_in = LN_SQUARE;
         LN_SQUARE: state_in = LN_SUM;
         LN_SUM:    state_in = LN_ROOT;
         LN_ROOT:   if (bit_ff == '0) state_in = LN_DONE;
         LN_DONE:   state_in = LN_IDLE;
         default:   state_in = LN_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      res.done   = (state_ff == LN_DONE);
      res.luma   = luma_ff;
      res.chroma = root_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LN_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers, advanced by state
   always_ff @(posedge clock) begin
      case (state_ff)
         LN_IDLE: begin
            if (start) begin
               chan_ff[0] <= red;
               chan_ff[1] <= green;
               chan_ff[2] <= blue;
               prod_ff[0] <= red * coef_red;
               prod_ff[1] <= green * coef_green;
               prod_ff[2] <= blue * coef_blue;
            end
         end
         LN_LUMA: begin
            luma_ff <= luma_sat;
         end
         LN_SQUARE: begin
            for (int i = 0; i < 3; i++) begin
               sq_ff[i] <= dsq[i][PROD_W-1:0];
            end
         end
         LN_SUM: begin
            sumsq_ff <= sq_total;
            root_ff  <= '0;
            bit_ff   <= BIT_IDX_W'(CHROMA_W - 1);
         end
         LN_ROOT: begin
            if (cand_sq <= sumsq_ff) begin
               root_ff <= cand;
            end
            bit_ff <= bit_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/flcm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flcm_div: serial unsigned divider
// Restoring division, one quotient bit per cycle; done pulses when the
// quotient is ready.
// ----------------------------------------------------------------------------
module flcm_div (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire [flcm_pkg::DIVD_W-1:0]   dividend,
   input  wire [flcm_pkg::DIVS_W-1:0]   divisor,
   output logic                         done,
   output logic [flcm_pkg::DIVD_W-1:0]  quotient
);
   import flcm_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic [DIVS_W-1:0]     rem_ff;
   logic [DIVS_W-1:0]     dvs_ff;
   logic [DIVD_W-1:0]     quo_ff;
   logic [DIVS_W:0]       rem_sh;
   logic                  fits;

   // shift in the next dividend bit and try the subtract
   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIVD_W-1]};
      fits   = (rem_sh >= {1'b0, dvs_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == DIV_CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == DIV_CNT_W'(1))) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
         cnt_ff <= DIV_CNT_W'(DIVD_W);
      end else if (busy_ff) begin
         rem_ff <= fits ? DIVS_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DIVS_W-1:0];
         quo_ff <= {quo_ff[DIVD_W-2:0], fits};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

### rtl/flcm_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flcm_merge: frame means, exposure offset and saturation ratio
// Four means through the shared divider, two log2 values by normalizing
// and repeated squaring, then the chroma ratio through the divider again,
// or RATIO_ONE when a chroma mean is at or below the floor.
module flcm_merge (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   input  wire [flcm_pkg::LUMA_SUM_W-1:0]    ref_luma_sum,
   input  wire [flcm_pkg::CHROMA_SUM_W-1:0]  ref_chroma_sum,
   input  wire [flcm_pkg::LUMA_SUM_W-1:0]    src_luma_sum,
   input  wire [flcm_pkg::CHROMA_SUM_W-1:0]  src_chroma_sum,
   input  wire [flcm_pkg::TALLY_W-1:0]       tally,
   input  wire [flcm_pkg::FLOOR_W-1:0]       floor_level,
   output flcm_pkg::merge_out_type           res
);
   import flcm_pkg::*;

   merge_state_type      state_ff, state_in;
   logic [1:0]           op_ff;
   logic                 lidx_ff;
   logic [MEAN_W-1:0]    mean_ff [4];
   logic [MEAN_W-1:0]    norm_ff;
   logic [MSB_W-1:0]     msb_ff;
   logic [MANT_W-1:0]    mant_ff;
   logic [FRAC_W-1:0]    frac_ff;
   logic [3:0]           step_ff;
   logic [LOG_W-1:0]     log_ff [2];
   logic [OUT_W-1:0]     ratio_ff;

   logic                 div_start;
   logic [DIVD_W-1:0]    div_dividend;
   logic [DIVS_W-1:0]    div_divisor;
   logic                 div_done;
   logic [DIVD_W-1:0]    div_quotient;

   logic [CHROMA_SUM_W-1:0] sum_sel;
   logic [MEAN_W-1:0]    luma_floor;
   logic [MEAN_W-1:0]    log_src;
   logic [2*MANT_W-1:0]  mant_sq;
   logic [MANT_W:0]      mant_next;
   logic                 at_floor;
   logic signed [LOG_W+1:0] log_diff;
   logic signed [LOG_W-5:0] expo_raw;
   logic [OUT_W-1:0]     expo;

   flcm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // operand selection
   always_comb begin
      case (op_ff)
         2'd0:    sum_sel = CHROMA_SUM_W'(ref_luma_sum);
         2'd1:    sum_sel = CHROMA_SUM_W'(src_luma_sum);
         2'd2:    sum_sel = ref_chroma_sum;
         default: sum_sel = src_chroma_sum;
      endcase
      luma_floor = (floor_level == '0) ? MEAN_W'(1) : MEAN_W'(floor_level);
      log_src    = lidx_ff ? mean_ff[1] : mean_ff[0];
      at_floor   = (mean_ff[2] <= MEAN_W'(floor_level))
                || (mean_ff[3] <= MEAN_W'(floor_level));
      mant_sq    = mant_ff * mant_ff;
      mant_next  = mant_sq[2*MANT_W-1:MANT_W-1];
   end

   // exposure: floor((diff + 32) / 64), clipped to +/-EXPO_LIMIT
   always_comb begin
      log_diff = $signed({2'b00, log_ff[0]}) - $signed({2'b00, log_ff[1]})
               + $signed((LOG_W+2)'(32));
      expo_raw = log_diff[LOG_W+1:6];
      if (expo_raw > $signed((LOG_W-4)'(EXPO_LIMIT))) begin
         expo = OUT_W'(EXPO_LIMIT);
      end else if (expo_raw < -$signed((LOG_W-4)'(EXPO_LIMIT))) begin
         expo = OUT_W'(-EXPO_LIMIT);
      end else begin
         expo = expo_raw[OUT_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MG_IDLE:        if (start) state_in = MG_DIV_START;
         MG_DIV_START:   state_in = MG_DIV_WAIT;
         MG_DIV_WAIT: begin
            if (div_done) state_in = (op_ff == 2'd3) ? MG_CLAMP : MG_DIV_START;
         end
         MG_CLAMP:       state_in = MG_NORM;
         MG_NORM:        if (norm_ff[MEAN_W-1]) state_in = MG_SQUARE;
         MG_SQUARE: begin
            if (step_ff == '0) state_in = lidx_ff ? MG_RATIO_CHECK : MG_CLAMP;
         end
         MG_RATIO_CHECK: state_in = at_floor ? MG_DONE : MG_RATIO_WAIT;
         MG_RATIO_WAIT:  if (div_done) state_in = MG_DONE;
         MG_DONE:        state_in = MG_IDLE;
         default:        state_in = MG_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      div_start    = 1'b0;
      div_dividend = {9'b0, sum_sel, 8'b0} + DIVD_W'(tally >> 1);
      div_divisor  = DIVS_W'(tally);
      case (state_ff)
         MG_DIV_START: begin
            div_start = 1'b1;
         end
         MG_RATIO_CHECK: begin
            div_start    = !at_floor;
            div_dividend = {mean_ff[2], 8'b0} + DIVD_W'(mean_ff[3] >> 1);
            div_divisor  = mean_ff[3];
         end
         default: begin
         end
      endcase
      res.done     = (state_ff == MG_DONE);
      res.exposure = expo;
      res.ratio    = ratio_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         MG_IDLE: begin
            op_ff   <= 2'd0;
            lidx_ff <= 1'b0;
         end
         MG_DIV_WAIT: begin
            if (div_done) begin
               mean_ff[op_ff] <= (tally == '0) ? '0 : div_quotient[MEAN_W-1:0];
               op_ff <= op_ff + 1'b1;
            end
         end
         MG_CLAMP: begin
            norm_ff <= (log_src < luma_floor) ? luma_floor : log_src;
            msb_ff  <= MSB_W'(MEAN_W - 1);
         end
         MG_NORM: begin
            if (norm_ff[MEAN_W-1]) begin
               mant_ff <= norm_ff[MEAN_W-1:MEAN_W-MANT_W];
               frac_ff <= '0;
               step_ff <= 4'd15;
            end else begin
               norm_ff <= {norm_ff[MEAN_W-2:0], 1'b0};
               msb_ff  <= msb_ff - 1'b1;
            end
         end
         MG_SQUARE: begin
            mant_ff <= mant_next[MANT_W] ? mant_next[MANT_W:1] : mant_next[MANT_W-1:0];
            frac_ff <= {frac_ff[FRAC_W-2:0], mant_next[MANT_W]};
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               log_ff[lidx_ff] <= {msb_ff, frac_ff[FRAC_W-2:0], mant_next[MANT_W]};
               lidx_ff <= 1'b1;
            end
         end
         MG_RATIO_CHECK: begin
            if (at_floor) ratio_ff <= OUT_W'(RATIO_ONE);
         end
         MG_RATIO_WAIT: begin
            if (div_done) begin
               ratio_ff <= (div_quotient[DIVD_W-1:OUT_W] != '0) ? '1
                         : div_quotient[OUT_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/frame_luma_chroma_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_luma_chroma_match: mean luma and chroma comparison of two frames
// Two pixel lanes (reference, source) work side by side on each beat; their
// luma and chroma go into saturating frame sums. The last pixel starts the
// merge stage, which forms the means, the exposure offset and the ratio.
//
//   channel  ports                         handshake
//   -------  ----------------------------  ---------------------------------
//   input    req_*                         start high while busy low
//   result   rsp_*                         rsp_strobe, one cycle, no stall
//   config   csr_we, csr_index, csr_wdata  write when csr_we is high
//
// A pixel beat runs the lane states luma, square, sum, a 17-step root, done.
// A last pixel adds the merge: four mean divides on the shared divider, two
// log2 passes of normalizing and squaring, and a ratio divide unless a chroma
// mean is at the floor, then rsp_strobe. busy covers the whole span.
// Reset is synchronous: sums, tally and control clear, registers reload.
// ----------------------------------------------------------------------------
module frame_luma_chroma_match (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire [flcm_pkg::CHAN_W-1:0]         req_ref_red,
   input  wire [flcm_pkg::CHAN_W-1:0]         req_ref_green,
   input  wire [flcm_pkg::CHAN_W-1:0]         req_ref_blue,
   input  wire [flcm_pkg::CHAN_W-1:0]         req_src_red,
   input  wire [flcm_pkg::CHAN_W-1:0]         req_src_green,
   input  wire [flcm_pkg::CHAN_W-1:0]         req_src_blue,
   input  wire                                req_is_last,
   output logic                               rsp_strobe,
   output logic signed [flcm_pkg::OUT_W-1:0]  rsp_exposure_offset,
   output logic [flcm_pkg::OUT_W-1:0]         rsp_saturation_ratio,
   input  wire                                csr_we,
   input  wire [flcm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [flcm_pkg::CSR_W-1:0]          csr_wdata
);
   import flcm_pkg::*;

   top_state_type            state_ff, state_in;
   logic [COEF_W-1:0]        coef_red_ff, coef_green_ff, coef_blue_ff;
   logic [FLOOR_W-1:0]       floor_ff;
   logic [LUMA_SUM_W-1:0]    ref_luma_ff, src_luma_ff;
   logic [CHROMA_SUM_W-1:0]  ref_chroma_ff, src_chroma_ff;
   logic [TALLY_W-1:0]       tally_ff;
   logic                     last_ff;
   logic                     rsp_strobe_ff;
   logic [OUT_W-1:0]         rsp_expo_ff, rsp_ratio_ff;

   logic                     accept;
   logic                     lane_done;
   logic                     merge_start;
   logic                     room;
   lane_out_type             ref_res, src_res;
   merge_out_type            merge_res;
   logic [LUMA_SUM_W:0]      ref_luma_add, src_luma_add;
   logic [CHROMA_SUM_W:0]    ref_chroma_add, src_chroma_add;

   flcm_lane u_ref_lane (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .red        (req_ref_red),
      .green      (req_ref_green),
      .blue       (req_ref_blue),
      .coef_red   (coef_red_ff),
      .coef_green (coef_green_ff),
      .coef_blue  (coef_blue_ff),
      .res        (ref_res)
   );

   flcm_lane u_src_lane (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .red        (req_src_red),
      .green      (req_src_green),
      .blue       (req_src_blue),
      .coef_red   (coef_red_ff),
      .coef_green (coef_green_ff),
      .coef_blue  (coef_blue_ff),
      .res        (src_res)
   );

   flcm_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .start          (merge_start),
      .ref_luma_sum   (ref_luma_ff),
      .ref_chroma_sum (ref_chroma_ff),
      .src_luma_sum   (src_luma_ff),
      .src_chroma_sum (src_chroma_ff),
      .tally          (tally_ff),
      .floor_level    (floor_ff),
      .res            (merge_res)
   );

   // saturating sums; drop pixels once the tally is full
   always_comb begin
      room           = (tally_ff < TALLY_W'(MAX_PIXELS)) && (tally_ff != '1);
      ref_luma_add   = {1'b0, ref_luma_ff} + (LUMA_SUM_W+1)'(ref_res.luma);
      src_luma_add   = {1'b0, src_luma_ff} + (LUMA_SUM_W+1)'(src_res.luma);
      ref_chroma_add = {1'b0, ref_chroma_ff} + (CHROMA_SUM_W+1)'(ref_res.chroma);
      src_chroma_add = {1'b0, src_chroma_ff} + (CHROMA_SUM_W+1)'(src_res.chroma);
      lane_done      = ref_res.done;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TP_IDLE:  if (start) state_in = TP_LANE;
         TP_LANE:  if (lane_done) state_in = last_ff ? TP_MERGE : TP_IDLE;
         TP_MERGE: if (merge_res.done) state_in = TP_IDLE;
         default:  state_in = TP_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy        = (state_ff != TP_IDLE);
      accept      = (state_ff == TP_IDLE) && start;
      merge_start = (state_ff == TP_LANE) && lane_done && last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TP_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_red_ff   <= COEF_W'(17841);
         coef_green_ff <= COEF_W'(44177);
         coef_blue_ff  <= COEF_W'(3519);
         floor_ff      <= FLOOR_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_LUMA_RED:   coef_red_ff   <= csr_wdata[COEF_W-1:0];
            CSR_LUMA_GREEN: coef_green_ff <= csr_wdata[COEF_W-1:0];
            CSR_LUMA_BLUE:  coef_blue_ff  <= csr_wdata[COEF_W-1:0];
            CSR_FLOOR:      floor_ff      <= csr_wdata[FLOOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // frame sums: add on lane done, clear when the merge is done
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_luma_ff   <= '0;
         src_luma_ff   <= '0;
         ref_chroma_ff <= '0;
         src_chroma_ff <= '0;
         tally_ff      <= '0;
      end else if ((state_ff == TP_MERGE) && merge_res.done) begin
         ref_luma_ff   <= '0;
         src_luma_ff   <= '0;
         ref_chroma_ff <= '0;
         src_chroma_ff <= '0;
         tally_ff      <= '0;
      end else if ((state_ff == TP_LANE) && lane_done && room) begin
         ref_luma_ff   <= ref_luma_add[LUMA_SUM_W] ? '1 : ref_luma_add[LUMA_SUM_W-1:0];
         src_luma_ff   <= src_luma_add[LUMA_SUM_W] ? '1 : src_luma_add[LUMA_SUM_W-1:0];
         ref_chroma_ff <= ref_chroma_add[CHROMA_SUM_W] ? '1
                        : ref_chroma_add[CHROMA_SUM_W-1:0];
         src_chroma_ff <= src_chroma_add[CHROMA_SUM_W] ? '1
                        : src_chroma_add[CHROMA_SUM_W-1:0];
         tally_ff      <= tally_ff + 1'b1;
      end
   end

   // hold the last flag of the beat in flight
   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff <= req_is_last;
      end
   end

   // result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == TP_MERGE) && merge_res.done;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == TP_MERGE) && merge_res.done) begin
         rsp_expo_ff  <= merge_res.exposure;
         rsp_ratio_ff <= merge_res.ratio;
      end
   end

   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_exposure_offset  = $signed(rsp_expo_ff);
   assign rsp_saturation_ratio = rsp_ratio_ff;

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: frame luma and chroma match
// Streams reference and source pixel pairs into the block and groups them into
// frames with the last flag. A local model keeps the frame sums and register
// values, predicts the exposure offset and saturation ratio of each frame, and
// checks every result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   import flcm_pkg::*;

   typedef struct packed {
      logic [OUT_W-1:0] exposure;
      logic [OUT_W-1:0] ratio;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [CHAN_W-1:0] req_ref_red = '0, req_ref_green = '0, req_ref_blue = '0;
   logic [CHAN_W-1:0] req_src_red = '0, req_src_green = '0, req_src_blue = '0;
   logic req_is_last = 1'b0;
   logic rsp_strobe;
   logic signed [OUT_W-1:0] rsp_exposure_offset;
   logic [OUT_W-1:0] rsp_saturation_ratio;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   // model registers and frame sums
   longint unsigned coef_red, coef_green, coef_blue, floor_lvl;
   longint unsigned ref_luma_acc, ref_chroma_acc, src_luma_acc, src_chroma_acc;
   longint unsigned tally;

   frame_result_type frame_results_due[$];
   int unsigned errors = 0;
   int unsigned quiet_cycles = 0;
   bit burst = 0;

   frame_luma_chroma_match dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_ref_red(req_ref_red), .req_ref_green(req_ref_green),
      .req_ref_blue(req_ref_blue), .req_src_red(req_src_red),
      .req_src_green(req_src_green), .req_src_blue(req_src_blue),
      .req_is_last(req_is_last), .rsp_strobe(rsp_strobe),
      .rsp_exposure_offset(rsp_exposure_offset),
      .rsp_saturation_ratio(rsp_saturation_ratio),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- model
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // luma and chroma of one pixel, in channel LSBs
   task automatic pixel_luma_chroma(input longint unsigned r, g, b,
                                    output longint unsigned luma, chroma);
      longint dr, dg, db;
      luma = (r * coef_red + g * coef_green + b * coef_blue + 32768) >> 16;
      if (luma > 65535) luma = 65535;
      dr = longint'(r) - longint'(luma);
      dg = longint'(g) - longint'(luma);
      db = longint'(b) - longint'(luma);
      chroma = int_sqrt(longint'(dr * dr + dg * dg + db * db));
   endtask

   function automatic longint log2_fix16(longint unsigned x);
      int msb;
      longint unsigned m;
      longint res;
      msb = 63;
      while (msb > 0 && x[msb] == 1'b0) msb--;
      m = (msb <= 30) ? (x << (30 - msb)) : (x >> (msb - 30));
      res = longint'(msb) * 65536;
      for (int i = 15; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            res = res + (longint'(1) << i);
            m = m >> 1;
         end
      end
      return res;
   endfunction

   function automatic longint unsigned frame_mean(longint unsigned sum);
      if (tally == 0) return 0;
      return ((sum << 8) + (tally >> 1)) / tally;
   endfunction

   function automatic longint unsigned sum_add(longint unsigned a, b, top);
      return (a + b > top) ? top : a + b;
   endfunction

   // accumulate one accepted pixel pair; predict the frame result on the last
   task automatic predict_pixel(input longint unsigned rr, rg, rb, sr, sg, sb,
                                input bit last);
      longint unsigned rl, rc, sl, sc, mrl, mrc, msl, msc, lfloor, ratio;
      longint diff, expo;
      frame_result_type res;
      if (tally < MAX_PIXELS && tally < (64'd1 << TALLY_W) - 1) begin
         pixel_luma_chroma(rr, rg, rb, rl, rc);
         pixel_luma_chroma(sr, sg, sb, sl, sc);
         ref_luma_acc   = sum_add(ref_luma_acc, rl, (64'd1 << LUMA_SUM_W) - 1);
         ref_chroma_acc = sum_add(ref_chroma_acc, rc, (64'd1 << CHROMA_SUM_W) - 1);
         src_luma_acc   = sum_add(src_luma_acc, sl, (64'd1 << LUMA_SUM_W) - 1);
         src_chroma_acc = sum_add(src_chroma_acc, sc, (64'd1 << CHROMA_SUM_W) - 1);
         tally++;
      end
      if (last) begin
         mrl = frame_mean(ref_luma_acc);
         mrc = frame_mean(ref_chroma_acc);
         msl = frame_mean(src_luma_acc);
         msc = frame_mean(src_chroma_acc);
         lfloor = (floor_lvl == 0) ? 1 : floor_lvl;
         if (mrl < lfloor) mrl = lfloor;
         if (msl < lfloor) msl = lfloor;
         diff = log2_fix16(mrl) - log2_fix16(msl);
         expo = (diff + 32) >>> 6;
         if (expo > EXPO_LIMIT) expo = EXPO_LIMIT;
         if (expo < -EXPO_LIMIT) expo = -EXPO_LIMIT;
         if (mrc <= floor_lvl || msc <= floor_lvl) begin
            ratio = RATIO_ONE;
         end else begin
            ratio = ((mrc << 8) + (msc >> 1)) / msc;
            if (ratio > 65535) ratio = 65535;
         end
         res.exposure = expo[OUT_W-1:0];
         res.ratio = ratio[OUT_W-1:0];
         frame_results_due.push_back(res);
         ref_luma_acc = 0;
         ref_chroma_acc = 0;
         src_luma_acc = 0;
         src_chroma_acc = 0;
         tally = 0;
      end
   endtask

   // ------------------------------------------------------------- checking
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_strobe) begin
         if (frame_results_due.size() == 0) begin
            $error("result beat with no frame pending");
            errors++;
         end else begin
            want = frame_results_due.pop_front();
            if (rsp_exposure_offset !== want.exposure) begin
               $error("exposure_offset expected %0d actual %0d",
                      $signed(want.exposure), rsp_exposure_offset);
               errors++;
            end
            if (rsp_saturation_ratio !== want.ratio) begin
               $error("saturation_ratio expected %0d actual %0d",
                      want.ratio, rsp_saturation_ratio);
               errors++;
            end
         end
      end
   end

   // watchdog: count cycles with no beat of any kind
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || csr_we || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 20000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- driving
   task automatic send_pixel(input logic [CHAN_W-1:0] rr, rg, rb, sr, sg, sb,
                             input bit last);
      int gap;
      @(posedge clock);
      start <= 1'b1;
      req_ref_red <= rr;  req_ref_green <= rg;  req_ref_blue <= rb;
      req_src_red <= sr;  req_src_green <= sg;  req_src_blue <= sb;
      req_is_last <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_pixel(rr, rg, rb, sr, sg, sb, last);
      // hold start through a zero gap so the next beat is not re-raised
      if ($urandom_range(0, 39) == 0) burst = ~burst;
      gap = burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap - 1) @(posedge clock);
      end
   endtask

   // drain all frames, then let the merge stage settle
   task automatic settle();
      @(posedge clock);
      start <= 1'b0;
      while (frame_results_due.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input longint unsigned val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_LUMA_RED:   coef_red = val & 16'hFFFF;
         CSR_LUMA_GREEN: coef_green = val & 16'hFFFF;
         CSR_LUMA_BLUE:  coef_blue = val & 16'hFFFF;
         CSR_FLOOR:      floor_lvl = val & 24'hFFFFFF;
      endcase
   endtask

   task automatic write_all(input longint unsigned cr, cg, cb, fl);
      write_reg(CSR_LUMA_RED, cr);
      write_reg(CSR_LUMA_GREEN, cg);
      write_reg(CSR_LUMA_BLUE, cb);
      write_reg(CSR_FLOOR, fl);
   endtask

   function automatic logic [CHAN_W-1:0] rand_chan();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return CHAN_W'($urandom_range(0, 15));
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------ tests
   task automatic test_field_extremes();
      send_pixel(0, 0, 0, 0, 0, 0, 1);
      send_pixel('1, '1, '1, '1, '1, '1, 1);
      send_pixel('1, '1, '1, 0, 0, 0, 1);
      send_pixel(0, 0, 0, '1, '1, '1, 1);
      send_pixel('1, 0, '1, 0, '1, 0, 0);
      send_pixel(16'h1234, 16'h8000, 16'h00FF, 16'h7FFF, 16'h0001, 16'hFFFE, 0);
      send_pixel(16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 16'h3333, 16'hCCCC, 1);
      settle();
   endtask

   task automatic test_special_cases();
      // ratio overflow: bright red over a barely colored source
      send_pixel('1, 0, 0, 1, 0, 0, 1);
      // chroma at floor: the gray reference carries no chroma
      send_pixel(16'h4000, 16'h4000, 16'h4000, 16'h8000, 16'h8000, 16'h8000, 1);
      settle();
      // zero luma floor with a black frame
      write_reg(CSR_FLOOR, 0);
      send_pixel(0, 0, 0, 0, 0, 0, 1);
      send_pixel(0, 0, 0, 2, 0, 0, 1);
      send_pixel('1, 0, 0, 1, 0, 0, 1);
      settle();
      // floor above both luma means and the reference chroma mean: both outputs pinned
      write_reg(CSR_FLOOR, 24'hFFFFFF);
      send_pixel('1, 0, 0, 16'h0100, '1, 0, 1);
      settle();
   endtask

   task automatic test_register_extremes();
      write_all(65535, 65535, 65535, 1);
      send_pixel('1, '1, '1, 16'h0800, 0, 0, 1);
      send_pixel(16'h9000, 16'h1000, 16'h2000, 16'h0010, 16'h0020, 0, 1);
      settle();
      write_all(0, 0, 0, 0);
      send_pixel('1, 16'h1000, 0, 16'h0400, 0, 16'h0001, 1);
      send_pixel(16'h00FF, 16'h0F00, 16'hF000, 0, 0, 16'h0001, 1);
      settle();
   endtask

   task automatic test_random_frames(input int unsigned pixels);
      int unsigned sent, len;
      logic [CHAN_W-1:0] rr, rg, rb, sr, sg, sb;
      sent = 0;
      while (sent < pixels) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                           : $urandom_range(1, 12);
         for (int unsigned k = 0; k < len; k++) begin
            rr = rand_chan(); rg = rand_chan(); rb = rand_chan();
            if ($urandom_range(0, 4) == 0) begin
               // source as a dimmed copy of the reference
               sr = rr >> $urandom_range(0, 4);
               sg = rg >> $urandom_range(0, 4);
               sb = rb >> $urandom_range(0, 4);
            end else begin
               sr = rand_chan(); sg = rand_chan(); sb = rand_chan();
            end
            send_pixel(rr, rg, rb, sr, sg, sb, k == len - 1);
         end
         sent += len;
      end
      settle();
   endtask

   initial begin
      coef_red = 17841;  coef_green = 44177;  coef_blue = 3519;  floor_lvl = 1;
      ref_luma_acc = 0;  ref_chroma_acc = 0;
      src_luma_acc = 0;  src_chroma_acc = 0;  tally = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_special_cases();
      test_register_extremes();
      write_all(17841, 44177, 3519, 1);
      test_random_frames(400);
      write_all($urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 4096));
      test_random_frames(350);
      write_all(21845, 21845, 21846, 0);
      test_random_frames(300);
      write_all($urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 24'hFFFFFF));
      test_random_frames(300);

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
